FILE: design/ecc_pkg.sv
package ecc_pkg;

  localparam int unsigned FLOOR_W = 5;
  localparam int unsigned ACC_W   = 17;
  localparam int unsigned MSG_N   = 4;

  localparam logic [FLOOR_W-1:0] MAX_FLOOR = 5'd20;

  localparam logic [9:0]       TICK_MS_RST  = 10'd200;
  localparam logic [15:0]      DOOR_MS_RST  = 16'd1000;
  localparam logic [15:0]      FLOOR_MS_RST = 16'd1000;
  localparam logic [ACC_W-1:0] ACC_MAX      = '1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TICK_MS  = 2'd0;
  localparam logic [1:0] CFG_DOOR_MS  = 2'd1;
  localparam logic [1:0] CFG_FLOOR_MS = 2'd2;

  // Acknowledge and error codes carried in the message value.
  localparam logic [4:0] ACK_CALL   = 5'd0;
  localparam logic [4:0] ACK_OPEN   = 5'd1;
  localparam logic [4:0] ACK_CLOSE  = 5'd2;
  localparam logic [4:0] ACK_STATUS = 5'd3;
  localparam logic [4:0] ERR_MOVING = 5'd0;

  typedef enum logic [2:0] {
    CMD_CALL   = 3'd0,
    CMD_OPEN   = 3'd1,
    CMD_CLOSE  = 3'd2,
    CMD_STATUS = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    K_POS    = 3'd0,
    K_MOTION = 3'd1,
    K_DOOR   = 3'd2,
    K_ACK    = 3'd3,
    K_ERR    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MV_IDLE = 2'd0,
    MV_UP   = 2'd1,
    MV_DOWN = 2'd2
  } motion_e;

  typedef enum logic [1:0] {
    DR_CLOSED  = 2'd0,
    DR_OPENING = 2'd1,
    DR_OPEN    = 2'd2,
    DR_CLOSING = 2'd3
  } door_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [FLOOR_W-1:0] call_floor;
  } item_t;

  typedef struct packed {
    logic [9:0]  tick_ms;
    logic [15:0] door_ms;
    logic [15:0] floor_ms;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] value;
  } msg_t;

  // Messages caused by one command, in order, with their count (0 to 4).
  typedef struct packed {
    logic [2:0]            cnt;
    msg_t [MSG_N-1:0]      msgs;
  } bundle_t;

endpackage

FILE: design/ecc_cmd_if.sv
interface ecc_cmd_if import ecc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [FLOOR_W-1:0] call_floor;

  modport source (output valid, output cmd, output call_floor, input ready);
  modport sink   (input valid, input cmd, input call_floor, output ready);
endinterface

FILE: design/ecc_msg_if.sv
interface ecc_msg_if;
  logic       valid;
  logic       ready;
  logic [2:0] msg_kind;
  logic [4:0] msg_value;
  logic       last;

  modport source (output valid, output msg_kind, output msg_value, output last,
                  input ready);
  modport sink   (input valid, input msg_kind, input msg_value, input last,
                  output ready);
endinterface

FILE: design/ecc_cfg_if.sv
interface ecc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/ecc_cfg_regs.sv
module ecc_cfg_regs import ecc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  ecc_cfg_if.sink  cfg_ch,
  output cfg_t     cfg
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_ms  <= TICK_MS_RST;
      cfg_r.door_ms  <= DOOR_MS_RST;
      cfg_r.floor_ms <= FLOOR_MS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_TICK_MS:  cfg_r.tick_ms  <= cfg_ch.data[9:0];
        CFG_DOOR_MS:  cfg_r.door_ms  <= cfg_ch.data;
        CFG_FLOOR_MS: cfg_r.floor_ms <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/ecc_in_reg.sv
module ecc_in_reg import ecc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  ecc_cmd_if.sink  in_ch,
  input  logic     take,
  output logic     item_valid,
  output item_t    item
);

  logic  valid_r;
  item_t item_r;
  logic  accept;

  // The slot refills in the same cycle as the core consumes it.
  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd        <= in_ch.cmd;
      item_r.call_floor <= in_ch.call_floor;
    end
  end

endmodule

FILE: design/ecc_core.sv
module ecc_core import ecc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    item_valid,
  input  item_t   item,
  output logic    take,
  input  logic    bnd_ready,
  output logic    bnd_valid,
  output bundle_t bnd
);

  logic [FLOOR_W-1:0] cur_r, cur_nxt;
  logic [FLOOR_W-1:0] goal_r, goal_nxt;
  motion_e            motion_r, motion_nxt;
  door_e              door_r, door_nxt;
  logic [ACC_W-1:0]   door_el_r, door_el_nxt;
  logic [ACC_W-1:0]   trav_el_r, trav_el_nxt;

  logic [ACC_W:0]     door_sum, trav_sum;
  logic [ACC_W-1:0]   door_acc, trav_acc;
  logic [2:0]         n;
  bundle_t            b;
  logic               arrived;

  assign take = item_valid && bnd_ready;

  // Saturating accumulator sums for a tick.
  assign door_sum = {1'b0, door_el_r} + {{(ACC_W - 9){1'b0}}, cfg.tick_ms};
  assign trav_sum = {1'b0, trav_el_r} + {{(ACC_W - 9){1'b0}}, cfg.tick_ms};
  assign door_acc = door_sum[ACC_W] ? ACC_MAX : door_sum[ACC_W-1:0];
  assign trav_acc = trav_sum[ACC_W] ? ACC_MAX : trav_sum[ACC_W-1:0];

  always_comb begin
    cur_nxt     = cur_r;
    goal_nxt    = goal_r;
    motion_nxt  = motion_r;
    door_nxt    = door_r;
    door_el_nxt = door_el_r;
    trav_el_nxt = trav_el_r;
    b           = '0;
    n           = 3'd0;
    arrived     = 1'b0;
    if (take) begin
      case (item.cmd)
        CMD_CALL: begin
          if (item.call_floor != 5'd0 && item.call_floor <= MAX_FLOOR) begin
            goal_nxt = item.call_floor;
            if (door_r == DR_OPEN || door_r == DR_OPENING) begin
              door_nxt    = DR_CLOSING;
              door_el_nxt = '0;
              b.msgs[n[1:0]] = '{kind: K_DOOR, value: {3'b0, DR_CLOSING}};
              n = n + 3'd1;
            end
            if (item.call_floor == cur_r) begin
              b.msgs[n[1:0]] = '{kind: K_ACK, value: ACK_CALL};
              n = n + 3'd1;
              door_nxt    = DR_OPENING;
              door_el_nxt = '0;
              b.msgs[n[1:0]] = '{kind: K_DOOR, value: {3'b0, DR_OPENING}};
              n = n + 3'd1;
            end else begin
              if (motion_r == MV_IDLE) begin
                motion_nxt = (item.call_floor > cur_r) ? MV_UP : MV_DOWN;
                b.msgs[n[1:0]] = '{kind: K_MOTION, value: {3'b0, motion_nxt}};
                n = n + 3'd1;
              end
              b.msgs[n[1:0]] = '{kind: K_ACK, value: ACK_CALL};
              n = n + 3'd1;
            end
          end
        end
        CMD_OPEN: begin
          if (motion_r != MV_IDLE) begin
            b.msgs[n[1:0]] = '{kind: K_ERR, value: ERR_MOVING};
            n = n + 3'd1;
          end else begin
            if (door_r == DR_CLOSED || door_r == DR_CLOSING) begin
              door_nxt    = DR_OPENING;
              door_el_nxt = '0;
              b.msgs[n[1:0]] = '{kind: K_DOOR, value: {3'b0, DR_OPENING}};
              n = n + 3'd1;
            end
            b.msgs[n[1:0]] = '{kind: K_ACK, value: ACK_OPEN};
            n = n + 3'd1;
          end
        end
        CMD_CLOSE: begin
          if (door_r == DR_OPEN || door_r == DR_OPENING) begin
            door_nxt    = DR_CLOSING;
            door_el_nxt = '0;
            b.msgs[n[1:0]] = '{kind: K_DOOR, value: {3'b0, DR_CLOSING}};
            n = n + 3'd1;
          end
          b.msgs[n[1:0]] = '{kind: K_ACK, value: ACK_CLOSE};
          n = n + 3'd1;
        end
        CMD_STATUS: begin
          b.msgs[0] = '{kind: K_POS, value: cur_r};
          b.msgs[1] = '{kind: K_MOTION, value: {3'b0, motion_r}};
          b.msgs[2] = '{kind: K_DOOR, value: {3'b0, door_r}};
          b.msgs[3] = '{kind: K_ACK, value: ACK_STATUS};
          n = 3'd4;
        end
        CMD_TICK: begin
          if (door_r == DR_OPENING || door_r == DR_CLOSING) begin
            door_el_nxt = door_acc;
            if (door_acc >= {1'b0, cfg.door_ms}) begin
              door_nxt = (door_r == DR_OPENING) ? DR_OPEN : DR_CLOSED;
              b.msgs[n[1:0]] = '{kind: K_DOOR, value: {3'b0, door_nxt}};
              n = n + 3'd1;
            end
          end
          // Travel only sees the door as it stands after this tick.
          if (motion_r != MV_IDLE && door_nxt == DR_CLOSED) begin
            trav_el_nxt = trav_acc;
            if (trav_acc >= {1'b0, cfg.floor_ms}) begin
              trav_el_nxt = '0;
              cur_nxt = (motion_r == MV_UP) ? cur_r + 5'd1 : cur_r - 5'd1;
              b.msgs[n[1:0]] = '{kind: K_POS, value: cur_nxt};
              n = n + 3'd1;
              arrived = (motion_r == MV_UP) ? (cur_nxt >= goal_r)
                                            : (cur_nxt <= goal_r);
              if (arrived) begin
                motion_nxt = MV_IDLE;
                b.msgs[n[1:0]] = '{kind: K_MOTION, value: {3'b0, MV_IDLE}};
                n = n + 3'd1;
                door_nxt    = DR_OPENING;
                door_el_nxt = '0;
                b.msgs[n[1:0]] = '{kind: K_DOOR, value: {3'b0, DR_OPENING}};
                n = n + 3'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    b.cnt = n;
  end

  assign bnd       = b;
  assign bnd_valid = take && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= 5'd1;
      goal_r    <= 5'd1;
      motion_r  <= MV_IDLE;
      door_r    <= DR_CLOSED;
      door_el_r <= '0;
      trav_el_r <= '0;
    end else begin
      cur_r     <= cur_nxt;
      goal_r    <= goal_nxt;
      motion_r  <= motion_nxt;
      door_r    <= door_nxt;
      door_el_r <= door_el_nxt;
      trav_el_r <= trav_el_nxt;
    end
  end

endmodule

FILE: design/ecc_msg_out.sv
module ecc_msg_out import ecc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     bnd_valid,
  input  bundle_t  bnd,
  output logic     bnd_ready,
  ecc_msg_if.source out_ch
);

  logic       busy_r;
  bundle_t    bnd_r;
  logic [1:0] idx_r;
  logic       is_last;
  logic       beat;
  msg_t       cur_msg;

  assign cur_msg = bnd_r.msgs[idx_r];
  assign is_last = ({1'b0, idx_r} + 3'd1) == bnd_r.cnt;
  assign beat    = busy_r && out_ch.ready;

  // A new run may load on the cycle its predecessor's final beat leaves.
  assign bnd_ready = !busy_r || (beat && is_last);

  assign out_ch.valid     = busy_r;
  assign out_ch.msg_kind  = cur_msg.kind;
  assign out_ch.msg_value = cur_msg.value;
  assign out_ch.last      = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (bnd_valid && bnd_ready) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (beat) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_valid && bnd_ready) begin
      bnd_r <= bnd;
    end
  end

endmodule

FILE: design/elevator_car_controller_top.sv
// Single-car elevator controller. Each beat on the command channel is a call
// to a floor, a door open, a door close, a status query or a timer tick, and
// it answers with a run of zero to four event beats (position, motion, door,
// acknowledge, error) on the message channel, the final beat of each run
// flagged by last. A command first lands in an input register; once the
// output buffer can take a run, the controller state is updated and the
// whole run of messages is formed at once and handed to that buffer, which
// then issues one message per cycle while the sink is ready. The input
// register takes a new command while an earlier run is still draining; the
// core takes the next command only when the buffer can load its run, so the
// message buffer paces the commands. Door and travel timing come from the
// tick_ms, door_ms and floor_ms registers; by the user's rule they are
// written through the configuration channel only while the block is idle,
// which the block itself does not enforce. A write to an index beyond the
// three registers is taken and has no effect.
module elevator_car_controller_top import ecc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ecc_cmd_if.sink    in_ch,
  ecc_msg_if.source  out_ch,
  ecc_cfg_if.sink    cfg_ch
);

  cfg_t    cfg;
  logic    item_valid;
  item_t   item;
  logic    take;
  logic    bnd_ready;
  logic    bnd_valid;
  bundle_t bnd;

  // Timing registers.
  ecc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Command input register, refilled as the core consumes it.
  ecc_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Controller state and message formation, one command per cycle while the output buffer is ready.
  ecc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .bnd_ready  (bnd_ready),
    .bnd_valid  (bnd_valid),
    .bnd        (bnd)
  );

  // Output buffer that issues a run one beat at a time.
  ecc_msg_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .bnd_valid (bnd_valid),
    .bnd       (bnd),
    .bnd_ready (bnd_ready),
    .out_ch    (out_ch)
  );

endmodule
